/* rtl/core/ahfp_pkg.sv */
// Shared types, character codes and a helper function for the ASCII hex frame parser.
// No dependencies; the configuration, parser and top-level modules import this package.
package ahfp_pkg;

    // Character codes that the frame grammar uses.
    localparam logic [7:0] CH_HASH  = 8'h23;  // '#'
    localparam logic [7:0] CH_T_LO  = 8'h74;  // 't'
    localparam logic [7:0] CH_T_UP  = 8'h54;  // 'T'
    localparam logic [7:0] CH_P_LO  = 8'h70;  // 'p'
    localparam logic [7:0] CH_P_UP  = 8'h50;  // 'P'
    localparam logic [7:0] CH_R_LO  = 8'h72;  // 'r'
    localparam logic [7:0] CH_W_LO  = 8'h77;  // 'w'
    localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
    localparam logic [7:0] CH_NINE  = 8'h39;  // '9'
    localparam logic [7:0] CH_A_UP  = 8'h41;  // 'A'
    localparam logic [7:0] CH_F_UP  = 8'h46;  // 'F'
    localparam logic [7:0] CH_Z_UP  = 8'h5A;  // 'Z'
    localparam logic [7:0] CH_A_LO  = 8'h61;  // 'a'
    localparam logic [7:0] CH_F_LO  = 8'h66;  // 'f'

    // Fixed number of non-data bytes in a frame.
    localparam logic [4:0] HEADER_TRAILER_LEN = 5'd12;

    // Configuration register indexes.
    localparam logic [1:0] REG_MAX_DATA_LEN  = 2'd0;
    localparam logic [1:0] REG_ADDR_ACCEPT_A = 2'd1;
    localparam logic [1:0] REG_ADDR_ACCEPT_B = 2'd2;

    // Result kinds.
    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_END  = 1'b1;

    typedef struct packed {
        logic [3:0] max_data_len;
        logic [7:0] addr_accept_a;
        logic [7:0] addr_accept_b;
    } t_cfg;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
        logic       frame_ok;
        logic [7:0] src_addr;
        logic [7:0] dst_addr;
        logic       is_write;
        logic [7:0] id_first;
        logic [7:0] id_second;
        logic [7:0] id_third;
        logic [3:0] data_count;
    } t_result;

    // Upper-case hex character for the low nibble of a value.
    function automatic logic [7:0] nibble_char(input logic [3:0] v);
        logic [7:0] c;
        if (v <= 4'd9) begin
            c = CH_ZERO + {4'd0, v};
        end else begin
            c = CH_A_UP + {4'd0, v} - 8'd10;
        end
        return c;
    endfunction

endpackage

/* rtl/core/ahfp_rx_if.sv */
// Handshake channel that carries one received byte per transaction.
// No dependencies.
interface ahfp_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

/* rtl/core/ahfp_res_if.sv */
// Handshake channel that carries one parser result per transaction.
// No dependencies.
interface ahfp_res_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] data_byte;
    logic       frame_ok;
    logic [7:0] src_addr;
    logic [7:0] dst_addr;
    logic       is_write;
    logic [7:0] id_first;
    logic [7:0] id_second;
    logic [7:0] id_third;
    logic [3:0] data_count;

    modport source (
        output valid, output kind, output data_byte, output frame_ok,
        output src_addr, output dst_addr, output is_write,
        output id_first, output id_second, output id_third, output data_count,
        input ready
    );
    modport sink (
        input valid, input kind, input data_byte, input frame_ok,
        input src_addr, input dst_addr, input is_write,
        input id_first, input id_second, input id_third, input data_count,
        output ready
    );
endinterface

/* rtl/core/ascii_hex_frame_parser.sv */
// Top level of the ASCII hex frame parser: input register, parser and result register.
// Depends on ahfp_pkg, ahfp_rx_if, ahfp_res_if, ahfp_cfg and ahfp_parse.
//
// Usage:
// Received bytes arrive on the i_rx channel, one byte per transaction. The parser
// looks for frames made of '#', t/T, p/P, two address bytes, a hex length digit,
// r/w, a three-character identifier, the data bytes and two upper-case hex
// checksum characters. Each data byte is delivered on o_res as a transaction of
// kind data; the last checksum character yields one end-of-frame transaction with
// the header fields and the checksum verdict. Bytes that break the pattern are
// dropped silently and the parser waits for the next '#'.
// Throughput is one byte per cycle unless o_res stalls. A byte accepted on i_rx is
// held in the input register and parsed from there, and its result, if any, is
// captured in the result register that drives o_res. The per-byte update is a
// single pass of the parser state machine, which sets that rate.
// When the receiver holds o_res.ready low with a result pending, the result and
// input registers hold and i_rx.ready drops once the input register is full;
// nothing is lost. Synchronous reset clears the parser to waiting for '#',
// empties both registers and restores the configuration defaults.
// Configuration is written through i_cfg_we, i_cfg_idx and i_cfg_data; the user
// must write it only while idle, which the block itself does not enforce.
module ascii_hex_frame_parser (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [7:0] i_cfg_data,
    ahfp_rx_if.sink    i_rx,
    ahfp_res_if.source o_res
);
    import ahfp_pkg::*;

    t_cfg      cfg;
    logic      r_in_valid;
    logic [7:0] r_in_byte;
    logic      r_out_valid;
    t_result   r_out;
    logic      advance;
    logic      step;
    logic      res_valid;
    t_result   res;

    ahfp_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_idx   (i_cfg_idx),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    // The pipeline moves whenever the result register is empty or being taken.
    assign advance    = !r_out_valid || o_res.ready;
    assign step       = r_in_valid && advance;
    assign i_rx.ready = !r_in_valid || advance;

    ahfp_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_byte      (r_in_byte),
        .i_cfg       (cfg),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_in_valid <= i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.ready && i_rx.valid) begin
            r_in_byte <= i_rx.rx_byte;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= step && res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && res_valid) begin
            r_out <= res;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.kind       = r_out.kind;
    assign o_res.data_byte  = r_out.data_byte;
    assign o_res.frame_ok   = r_out.frame_ok;
    assign o_res.src_addr   = r_out.src_addr;
    assign o_res.dst_addr   = r_out.dst_addr;
    assign o_res.is_write   = r_out.is_write;
    assign o_res.id_first   = r_out.id_first;
    assign o_res.id_second  = r_out.id_second;
    assign o_res.id_third   = r_out.id_third;
    assign o_res.data_count = r_out.data_count;

endmodule

/* rtl/core/ahfp_cfg.sv */
// Configuration register file of the ASCII hex frame parser.
// Depends on ahfp_pkg.
module ahfp_cfg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_we,
    input  logic [1:0]    i_idx,
    input  logic [7:0]    i_data,
    output ahfp_pkg::t_cfg o_cfg
);
    import ahfp_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_data_len  <= 4'd15;
            r_cfg.addr_accept_a <= 8'd0;
            r_cfg.addr_accept_b <= 8'd0;
        end else if (i_we) begin
            unique case (i_idx)
                REG_MAX_DATA_LEN:  r_cfg.max_data_len  <= i_data[3:0];
                REG_ADDR_ACCEPT_A: r_cfg.addr_accept_a <= i_data;
                REG_ADDR_ACCEPT_B: r_cfg.addr_accept_b <= i_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* rtl/core/ahfp_parse.sv */
// Frame parser state machine: consumes one byte per step and forms at most one result.
// Depends on ahfp_pkg.
module ahfp_parse (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [7:0]        i_byte,
    input  ahfp_pkg::t_cfg    i_cfg,
    output logic              o_res_valid,
    output ahfp_pkg::t_result o_res
);
    import ahfp_pkg::*;

    typedef enum logic [3:0] {
        ST_HDR1  = 4'd0,
        ST_HDR2  = 4'd1,
        ST_HDR3  = 4'd2,
        ST_ADDR1 = 4'd3,
        ST_ADDR2 = 4'd4,
        ST_LEN   = 4'd5,
        ST_CTRL  = 4'd6,
        ST_ID1   = 4'd7,
        ST_ID2   = 4'd8,
        ST_ID3   = 4'd9,
        ST_DATA  = 4'd10,
        ST_SUMH  = 4'd11,
        ST_SUML  = 4'd12
    } t_state;

    t_state     r_state, n_state;
    logic [3:0] r_decl_len, n_decl_len;
    logic [3:0] r_data_seen, n_data_seen;
    logic [7:0] r_sum, n_sum;
    logic [7:0] r_addr0, n_addr0;
    logic [7:0] r_addr1, n_addr1;
    logic       r_wr, n_wr;
    logic [7:0] r_id0, n_id0;
    logic [7:0] r_id1, n_id1;
    logic [7:0] r_id2, n_id2;
    logic [7:0] r_sum_hi, n_sum_hi;

    logic [4:0] count;
    logic       guard;
    logic       fail;
    logic       hex_ok;
    logic [3:0] hex_val;
    logic       id_char_ok;
    logic       addr_ok;
    logic [4:0] got;

    // Decode the byte as a hex digit, either case.
    always_comb begin
        hex_ok  = 1'b1;
        hex_val = 4'd0;
        if (i_byte >= CH_ZERO && i_byte <= CH_NINE) begin
            hex_val = 4'(i_byte - CH_ZERO);
        end else if (i_byte >= CH_A_UP && i_byte <= CH_F_UP) begin
            hex_val = 4'(i_byte - CH_A_UP + 8'd10);
        end else if (i_byte >= CH_A_LO && i_byte <= CH_F_LO) begin
            hex_val = 4'(i_byte - CH_A_LO + 8'd10);
        end else begin
            hex_ok = 1'b0;
        end
    end

    assign id_char_ok = (i_byte >= CH_A_UP && i_byte <= CH_Z_UP) ||
                        (i_byte >= CH_ZERO && i_byte <= CH_NINE);
    assign addr_ok    = (i_byte == i_cfg.addr_accept_a) || (i_byte == i_cfg.addr_accept_b);
    assign got        = {1'b0, r_data_seen} + 5'd1;

    // Byte count of the frame including the current byte.
    always_comb begin
        if (r_state <= ST_ID3) begin
            count = {1'b0, r_state} + 5'd1;
        end else if (r_state == ST_DATA) begin
            count = 5'd11 + {1'b0, r_data_seen};
        end else if (r_state == ST_SUMH) begin
            count = 5'd11 + {1'b0, r_decl_len};
        end else begin
            count = 5'd12 + {1'b0, r_decl_len};
        end
    end

    assign guard = count >= (HEADER_TRAILER_LEN + {1'b0, i_cfg.max_data_len});

    always_comb begin
        n_state     = r_state;
        n_decl_len  = r_decl_len;
        n_data_seen = r_data_seen;
        n_sum       = r_sum;
        n_addr0     = r_addr0;
        n_addr1     = r_addr1;
        n_wr        = r_wr;
        n_id0       = r_id0;
        n_id1       = r_id1;
        n_id2       = r_id2;
        n_sum_hi    = r_sum_hi;
        fail        = 1'b0;
        o_res_valid = 1'b0;
        o_res       = '0;

        unique case (r_state)
            ST_HDR1: begin
                if (i_byte == CH_HASH) n_state = ST_HDR2; else fail = 1'b1;
            end
            ST_HDR2: begin
                if (i_byte == CH_T_LO || i_byte == CH_T_UP) n_state = ST_HDR3;
                else fail = 1'b1;
            end
            ST_HDR3: begin
                if (i_byte == CH_P_LO || i_byte == CH_P_UP) n_state = ST_ADDR1;
                else fail = 1'b1;
            end
            ST_ADDR1: begin
                if (addr_ok) begin
                    n_addr0 = i_byte;
                    n_state = ST_ADDR2;
                end else fail = 1'b1;
            end
            ST_ADDR2: begin
                if (addr_ok) begin
                    n_addr1 = i_byte;
                    n_state = ST_LEN;
                end else fail = 1'b1;
            end
            ST_LEN: begin
                if (hex_ok && hex_val <= i_cfg.max_data_len) begin
                    n_decl_len = hex_val;
                    n_state    = ST_CTRL;
                end else fail = 1'b1;
            end
            ST_CTRL: begin
                if (i_byte == CH_R_LO || i_byte == CH_W_LO) begin
                    n_wr    = (i_byte == CH_W_LO);
                    n_state = ST_ID1;
                end else fail = 1'b1;
            end
            ST_ID1: begin
                if (id_char_ok) begin
                    n_id0   = i_byte;
                    n_state = ST_ID2;
                end else fail = 1'b1;
            end
            ST_ID2: begin
                if (id_char_ok) begin
                    n_id1   = i_byte;
                    n_state = ST_ID3;
                end else fail = 1'b1;
            end
            ST_ID3: begin
                if (id_char_ok) begin
                    n_id2   = i_byte;
                    n_state = (r_decl_len == 4'd0) ? ST_SUMH : ST_DATA;
                end else fail = 1'b1;
            end
            ST_DATA: begin
                if (got > {1'b0, i_cfg.max_data_len}) begin
                    fail = 1'b1;
                end else begin
                    n_data_seen = got[3:0];
                    if (got == {1'b0, r_decl_len}) n_state = ST_SUMH;
                    o_res_valid     = 1'b1;
                    o_res.kind      = KIND_DATA;
                    o_res.data_byte = i_byte;
                end
            end
            ST_SUMH: begin
                n_sum_hi = i_byte;
                n_state  = ST_SUML;
            end
            ST_SUML: begin
                o_res_valid      = 1'b1;
                o_res.kind       = KIND_END;
                o_res.frame_ok   = (r_sum_hi == nibble_char(r_sum[7:4])) &&
                                   (i_byte == nibble_char(r_sum[3:0]));
                o_res.src_addr   = r_addr0;
                o_res.dst_addr   = r_addr1;
                o_res.is_write   = r_wr;
                o_res.id_first   = r_id0;
                o_res.id_second  = r_id1;
                o_res.id_third   = r_id2;
                o_res.data_count = r_decl_len;
                fail             = 1'b1;
            end
            default: begin
                fail = 1'b1;
            end
        endcase

        // A broken pattern, an over-long frame or a finished frame drops back to the start.
        if (fail || guard) begin
            n_state     = ST_HDR1;
            n_sum       = 8'd0;
            n_data_seen = 4'd0;
        end else if (r_state <= ST_DATA) begin
            n_sum = r_sum + i_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_HDR1;
            r_decl_len  <= 4'd0;
            r_data_seen <= 4'd0;
            r_sum       <= 8'd0;
            r_addr0     <= 8'd0;
            r_addr1     <= 8'd0;
            r_wr        <= 1'b0;
            r_id0       <= 8'd0;
            r_id1       <= 8'd0;
            r_id2       <= 8'd0;
            r_sum_hi    <= 8'd0;
        end else if (i_step) begin
            r_state     <= n_state;
            r_decl_len  <= n_decl_len;
            r_data_seen <= n_data_seen;
            r_sum       <= n_sum;
            r_addr0     <= n_addr0;
            r_addr1     <= n_addr1;
            r_wr        <= n_wr;
            r_id0       <= n_id0;
            r_id1       <= n_id1;
            r_id2       <= n_id2;
            r_sum_hi    <= n_sum_hi;
        end
    end

endmodule
